[hw/rtl/spi_pkg.sv]
package spi_pkg;

    // Result classification codes.
    localparam logic [1:0] STATUS_NONE    = 2'd0;
    localparam logic [1:0] STATUS_CROSS   = 2'd1;
    localparam logic [1:0] STATUS_OVERLAP = 2'd2;

    // Control word that travels beside the divider data.
    typedef struct packed {
        logic       valid;
        logic [1:0] status;
        logic       neg_x;
        logic       neg_y;
    } spi_ctrl_t;

endpackage

[hw/rtl/spi_front.sv]
module spi_front #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic signed [COORD_BITS-1:0]           first_start_x,
    input  logic signed [COORD_BITS-1:0]           first_start_y,
    input  logic signed [COORD_BITS-1:0]           first_end_x,
    input  logic signed [COORD_BITS-1:0]           first_end_y,
    input  logic signed [COORD_BITS-1:0]           second_start_x,
    input  logic signed [COORD_BITS-1:0]           second_start_y,
    input  logic signed [COORD_BITS-1:0]           second_end_x,
    input  logic signed [COORD_BITS-1:0]           second_end_y,
    output spi_pkg::spi_ctrl_t                     out_ctrl,
    output logic [2*COORD_BITS:0]                  out_den,
    output logic [3*COORD_BITS:0]                  out_prod_x,
    output logic [3*COORD_BITS:0]                  out_prod_y,
    output logic [31:0]                            out_base_x,
    output logic [31:0]                            out_base_y
);
    import spi_pkg::*;

    localparam int D     = COORD_BITS + 1;
    localparam int P     = 2 * D;
    localparam int S     = 2 * COORD_BITS + 4;
    localparam int DEN_W = 2 * COORD_BITS + 1;

    // Stage valid bits.
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Stage 1: direction vectors and the offset between the start points.
    logic signed [COORD_BITS-1:0] p0x1_reg, p0y1_reg;
    logic signed [D-1:0] d1x_reg, d1y_reg, d2x_reg, d2y_reg, ex_reg, ey_reg;
    logic zero1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p0x1_reg  <= first_start_x;
            p0y1_reg  <= first_start_y;
            d1x_reg   <= D'(first_end_x) - D'(first_start_x);
            d1y_reg   <= D'(first_end_y) - D'(first_start_y);
            d2x_reg   <= D'(second_end_x) - D'(second_start_x);
            d2y_reg   <= D'(second_end_y) - D'(second_start_y);
            ex_reg    <= D'(first_start_x) - D'(second_start_x);
            ey_reg    <= D'(first_start_y) - D'(second_start_y);
            zero1_reg <= (first_end_x == first_start_x && first_end_y == first_start_y) ||
                         (second_end_x == second_start_x && second_end_y == second_start_y);
        end
    end

    // Stage 2: all pairwise products.
    logic signed [P-1:0] m_cr_a, m_cr_b, m_nu_a, m_nu_b, m_nv_a, m_nv_b;
    logic signed [P-1:0] m_ed1_a, m_ed1_b, m_d12_a, m_d12_b, m_ed2_a, m_ed2_b;
    logic signed [P-1:0] m_l1_a, m_l1_b, m_l2_a, m_l2_b;
    logic signed [COORD_BITS-1:0] p0x2_reg, p0y2_reg;
    logic signed [D-1:0] d1x2_reg, d1y2_reg;
    logic zero2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m_cr_a    <= d1x_reg * d2y_reg;
            m_cr_b    <= d1y_reg * d2x_reg;
            m_nu_a    <= ex_reg * d2y_reg;
            m_nu_b    <= d2x_reg * ey_reg;
            m_nv_a    <= d1y_reg * ex_reg;
            m_nv_b    <= d1x_reg * ey_reg;
            m_ed1_a   <= ex_reg * d1x_reg;
            m_ed1_b   <= ey_reg * d1y_reg;
            m_d12_a   <= d1x_reg * d2x_reg;
            m_d12_b   <= d1y_reg * d2y_reg;
            m_ed2_a   <= ex_reg * d2x_reg;
            m_ed2_b   <= ey_reg * d2y_reg;
            m_l1_a    <= d1x_reg * d1x_reg;
            m_l1_b    <= d1y_reg * d1y_reg;
            m_l2_a    <= d2x_reg * d2x_reg;
            m_l2_b    <= d2y_reg * d2y_reg;
            p0x2_reg  <= p0x1_reg;
            p0y2_reg  <= p0y1_reg;
            d1x2_reg  <= d1x_reg;
            d1y2_reg  <= d1y_reg;
            zero2_reg <= zero1_reg;
        end
    end

    // Stage 3: cross products and dot products.
    logic signed [S-1:0] cr_reg, nu_reg, nv_reg, ed1_reg, d12_reg, ed2_reg, l1_reg, l2_reg;
    logic signed [COORD_BITS-1:0] p0x3_reg, p0y3_reg;
    logic signed [D-1:0] d1x3_reg, d1y3_reg;
    logic zero3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cr_reg    <= S'(m_cr_a) - S'(m_cr_b);
            nu_reg    <= S'(m_nu_a) - S'(m_nu_b);
            nv_reg    <= S'(m_nv_a) - S'(m_nv_b);
            ed1_reg   <= S'(m_ed1_a) + S'(m_ed1_b);
            d12_reg   <= S'(m_d12_a) + S'(m_d12_b);
            ed2_reg   <= S'(m_ed2_a) + S'(m_ed2_b);
            l1_reg    <= S'(m_l1_a) + S'(m_l1_b);
            l2_reg    <= S'(m_l2_a) + S'(m_l2_b);
            p0x3_reg  <= p0x2_reg;
            p0y3_reg  <= p0y2_reg;
            d1x3_reg  <= d1x2_reg;
            d1y3_reg  <= d1y2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    // Stage 4: sign normalization and the endpoint-on-segment tests.
    logic signed [S-1:0] t_q1, t_p1, neg_l1;
    logic                on_q0, on_q1, on_p0, on_p1, flip;
    logic [DEN_W-1:0]    den_next;

    always_comb begin
        flip     = !cr_reg[S-1] && (cr_reg != '0);
        den_next = cr_reg[S-1] ? DEN_W'(-cr_reg) : DEN_W'(cr_reg);
        neg_l1   = -l1_reg;
        t_q1     = d12_reg - ed1_reg;
        t_p1     = d12_reg + ed2_reg;
        on_q0    = (ed1_reg[S-1] || (ed1_reg == '0)) && (ed1_reg >= neg_l1);
        on_q1    = !t_q1[S-1] && (t_q1 <= l1_reg);
        on_p0    = !ed2_reg[S-1] && (ed2_reg <= l2_reg);
        on_p1    = !t_p1[S-1] && (t_p1 <= l2_reg);
    end

    logic signed [S-1:0] nuf_reg, nvf_reg;
    logic [DEN_W-1:0] den_reg;
    logic [COORD_BITS-1:0] magx_reg, magy_reg;
    logic negx_reg, negy_reg, crnz_reg, colin_reg, ovl_reg, zero4_reg;
    logic signed [COORD_BITS-1:0] p0x4_reg, p0y4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            nuf_reg   <= flip ? -nu_reg : nu_reg;
            nvf_reg   <= flip ? -nv_reg : nv_reg;
            den_reg   <= den_next;
            crnz_reg  <= cr_reg != '0;
            colin_reg <= nv_reg == '0;
            ovl_reg   <= on_q0 || on_q1 || on_p0 || on_p1;
            magx_reg  <= d1x3_reg[D-1] ? COORD_BITS'(-d1x3_reg) : COORD_BITS'(d1x3_reg);
            magy_reg  <= d1y3_reg[D-1] ? COORD_BITS'(-d1y3_reg) : COORD_BITS'(d1y3_reg);
            negx_reg  <= d1x3_reg[D-1];
            negy_reg  <= d1y3_reg[D-1];
            p0x4_reg  <= p0x3_reg;
            p0y4_reg  <= p0y3_reg;
            zero4_reg <= zero3_reg;
        end
    end

    // Stage 5: classification and the numerator times the span.
    logic signed [S-1:0] den_s;
    logic                in_range;
    logic [1:0]          status_next;

    always_comb begin
        den_s    = S'(den_reg);
        in_range = !nuf_reg[S-1] && (nuf_reg <= den_s) &&
                   !nvf_reg[S-1] && (nvf_reg <= den_s);
        if (zero4_reg) begin
            status_next = STATUS_NONE;
        end else if (crnz_reg) begin
            status_next = in_range ? STATUS_CROSS : STATUS_NONE;
        end else begin
            status_next = (colin_reg && ovl_reg) ? STATUS_OVERLAP : STATUS_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_ctrl <= '0;
        end else if (en) begin
            out_ctrl.valid  <= v4_reg;
            out_ctrl.status <= status_next;
            out_ctrl.neg_x  <= negx_reg;
            out_ctrl.neg_y  <= negy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_den    <= den_reg;
            out_prod_x <= nuf_reg[DEN_W-1:0] * magx_reg;
            out_prod_y <= nuf_reg[DEN_W-1:0] * magy_reg;
            out_base_x <= 32'(p0x4_reg) << FRAC_BITS;
            out_base_y <= 32'(p0y4_reg) << FRAC_BITS;
        end
    end

endmodule

[hw/rtl/spi_div.sv]
module spi_div #(
    parameter int DEN_W = 33,
    parameter int QW    = 32
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [DEN_W-1:0] den_in,
    input  logic [DEN_W-1:0] hi_in,
    input  logic [QW-1:0]    lo_in,
    output logic [QW-1:0]    q_out
);
    // One restoring step per stage. The word register holds the dividend
    // bits still to come on top and the quotient bits found so far below.
    logic [DEN_W-1:0] r_reg [QW];
    logic [QW-1:0]    w_reg [QW];
    logic [DEN_W-1:0] d_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DEN_W-1:0] r_in, d_in, r_next;
        logic [QW-1:0]    w_in, w_next;
        logic [DEN_W:0]   trial;
        logic             ge;

        always_comb begin
            if (k == 0) begin
                r_in = hi_in;
                w_in = lo_in;
                d_in = den_in;
            end else begin
                r_in = r_reg[(k == 0) ? 0 : k-1];
                w_in = w_reg[(k == 0) ? 0 : k-1];
                d_in = d_reg[(k == 0) ? 0 : k-1];
            end
            trial  = {r_in, w_in[QW-1]};
            ge     = trial >= {1'b0, d_in};
            r_next = ge ? DEN_W'(trial - {1'b0, d_in}) : DEN_W'(trial);
            w_next = {w_in[QW-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k] <= r_next;
                w_reg[k] <= w_next;
                d_reg[k] <= d_in;
            end
        end
    end

    assign q_out = w_reg[QW-1];

endmodule

[hw/rtl/segment_pair_intersection_unit.sv]
// Classifies a pair of 2D segments and gives their crossing point in signed
// fixed point with FRAC_BITS fraction bits, or reports collinear overlap.
// The unit takes one item per clock while its output is not stalled, and holds
// no state between items. An item passes through the front end's products,
// sums and classification, the pipelined restoring divider with one step per
// quotient bit, and the output register. When the output is not taken, the
// whole pipeline holds; no item is lost.
module segment_pair_intersection_unit #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_first_start_x,
    input  logic signed [COORD_BITS-1:0] s_first_start_y,
    input  logic signed [COORD_BITS-1:0] s_first_end_x,
    input  logic signed [COORD_BITS-1:0] s_first_end_y,
    input  logic signed [COORD_BITS-1:0] s_second_start_x,
    input  logic signed [COORD_BITS-1:0] s_second_start_y,
    input  logic signed [COORD_BITS-1:0] s_second_end_x,
    input  logic signed [COORD_BITS-1:0] s_second_end_y,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic signed [31:0]           m_cross_x,
    output logic signed [31:0]           m_cross_y
);
    import spi_pkg::*;

    localparam int DEN_W  = 2 * COORD_BITS + 1;
    localparam int PROD_W = 3 * COORD_BITS + 1;
    localparam int QW     = COORD_BITS + FRAC_BITS;

    logic en;
    logic m_valid_reg;

    // The pipeline moves whenever the output register is free or being read.
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    spi_ctrl_t         f_ctrl;
    logic [DEN_W-1:0]  f_den;
    logic [PROD_W-1:0] f_prod_x, f_prod_y;
    logic [31:0]       f_base_x, f_base_y;

    spi_front #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (s_valid),
        .first_start_x (s_first_start_x),
        .first_start_y (s_first_start_y),
        .first_end_x   (s_first_end_x),
        .first_end_y   (s_first_end_y),
        .second_start_x(s_second_start_x),
        .second_start_y(s_second_start_y),
        .second_end_x  (s_second_end_x),
        .second_end_y  (s_second_end_y),
        .out_ctrl      (f_ctrl),
        .out_den       (f_den),
        .out_prod_x    (f_prod_x),
        .out_prod_y    (f_prod_y),
        .out_base_x    (f_base_x),
        .out_base_y    (f_base_y)
    );

    // Two dividers, one per axis, sharing the same denominator.
    logic [QW-1:0] q_x, q_y;

    spi_div #(.DEN_W(DEN_W), .QW(QW)) u_div_x (
        .aclk  (aclk),
        .en    (en),
        .den_in(f_den),
        .hi_in (f_prod_x[PROD_W-1:COORD_BITS]),
        .lo_in ({f_prod_x[COORD_BITS-1:0], {FRAC_BITS{1'b0}}}),
        .q_out (q_x)
    );

    spi_div #(.DEN_W(DEN_W), .QW(QW)) u_div_y (
        .aclk  (aclk),
        .en    (en),
        .den_in(f_den),
        .hi_in (f_prod_y[PROD_W-1:COORD_BITS]),
        .lo_in ({f_prod_y[COORD_BITS-1:0], {FRAC_BITS{1'b0}}}),
        .q_out (q_y)
    );

    // Control and base points delayed to line up with the quotients.
    spi_ctrl_t   ctl_reg   [QW];
    logic [31:0] basex_reg [QW];
    logic [31:0] basey_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_delay
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[k] <= '0;
            end else if (en) begin
                ctl_reg[k] <= (k == 0) ? f_ctrl : ctl_reg[(k == 0) ? 0 : k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                basex_reg[k] <= (k == 0) ? f_base_x : basex_reg[(k == 0) ? 0 : k-1];
                basey_reg[k] <= (k == 0) ? f_base_y : basey_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // Output stage: add or subtract the scaled offset from the start point.
    spi_ctrl_t   last;
    logic [31:0] x_next, y_next;

    always_comb begin
        last   = ctl_reg[QW-1];
        x_next = '0;
        y_next = '0;
        if (last.status == STATUS_CROSS) begin
            x_next = last.neg_x ? basex_reg[QW-1] - 32'(q_x) : basex_reg[QW-1] + 32'(q_x);
            y_next = last.neg_y ? basey_reg[QW-1] - 32'(q_y) : basey_reg[QW-1] + 32'(q_y);
        end
    end

    logic [1:0]  status_reg;
    logic [31:0] x_reg, y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            status_reg <= last.status;
            x_reg      <= x_next;
            y_reg      <= y_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = status_reg;
    assign m_cross_x = x_reg;
    assign m_cross_y = y_reg;

    // A delivered item never carries an unused status code.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STATUS_NONE || m_status == STATUS_CROSS ||
                     m_status == STATUS_OVERLAP))
        else $error("invalid status code on output");

    // The point is zero unless a single crossing is reported.
    a_point_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STATUS_CROSS) |-> (m_cross_x == 0 && m_cross_y == 0))
        else $error("crossing point not zero without a crossing");

    // An item leaving the delay line is registered into the output.
    a_last_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && last.valid) |=> m_valid)
        else $error("item lost between divider and output");

    // While the output is held, the pipeline takes no new item.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while output stalled");

endmodule

[test/tb_top.sv]
module tb_top;
    import spi_pkg::*;

    // One pair of segments as it is put on the input channel.
    typedef struct packed {
        logic signed [15:0] first_start_x;
        logic signed [15:0] first_start_y;
        logic signed [15:0] first_end_x;
        logic signed [15:0] first_end_y;
        logic signed [15:0] second_start_x;
        logic signed [15:0] second_start_y;
        logic signed [15:0] second_end_x;
        logic signed [15:0] second_end_y;
    } seg_pair_t;

    // Classification and point expected for one pair.
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] cross_x;
        logic signed [31:0] cross_y;
    } crossing_t;

    class crossing_board;
        crossing_t pending_crossings[$];
        int        fail_count = 0;

        // Start plus the truncated share of the span, in Q16.16, low 32 bits kept.
        function logic [31:0] fixed_coord(longint start, longint span, longint num,
                                          longint den);
            logic [127:0] prod;
            logic [63:0]  quot;
            logic [63:0]  base;
            longint       mag;
            mag  = (span < 0) ? -span : span;
            prod = (128'(num) * 128'(mag)) << 16;
            quot = 64'(prod / 128'(den));
            base = 64'(start) << 16;
            return (span < 0) ? 32'(base - quot) : 32'(base + quot);
        endfunction

        // Projection of p onto a-b lies within the segment, ends included.
        function bit on_seg(longint ax, longint ay, longint bx, longint by,
                            longint px, longint py);
            longint dx;
            longint dy;
            longint t;
            dx = bx - ax;
            dy = by - ay;
            t  = (px - ax) * dx + (py - ay) * dy;
            return t >= 0 && t <= dx * dx + dy * dy;
        endfunction

        function void note_pair(seg_pair_t p);
            longint    ax, ay, bx, by, cx, cy, ex_, ey_;
            longint    d1x, d1y, d2x, d2y, cr, ox, oy, den, nu, nv;
            crossing_t r;
            ax = p.first_start_x;  ay = p.first_start_y;
            bx = p.first_end_x;    by = p.first_end_y;
            cx = p.second_start_x; cy = p.second_start_y;
            ex_ = p.second_end_x;  ey_ = p.second_end_y;
            d1x = bx - ax; d1y = by - ay;
            d2x = ex_ - cx; d2y = ey_ - cy;
            r = '{STATUS_NONE, 32'sd0, 32'sd0};
            cr = d1x * d2y - d1y * d2x;
            if ((d1x == 0 && d1y == 0) || (d2x == 0 && d2y == 0)) begin
                // A point is not a segment.
            end else if (cr != 0) begin
                ox  = ax - cx;
                oy  = ay - cy;
                den = -cr;
                nu  = ox * d2y - d2x * oy;
                nv  = d1y * ox - d1x * oy;
                if (den < 0) begin
                    den = -den;
                    nu  = -nu;
                    nv  = -nv;
                end
                if (nu >= 0 && nu <= den && nv >= 0 && nv <= den) begin
                    r.status  = STATUS_CROSS;
                    r.cross_x = fixed_coord(ax, d1x, nu, den);
                    r.cross_y = fixed_coord(ay, d1y, nu, den);
                end
            end else if (d1x * (cy - ay) - d1y * (cx - ax) == 0) begin
                if (on_seg(ax, ay, bx, by, cx, cy) || on_seg(ax, ay, bx, by, ex_, ey_) ||
                    on_seg(cx, cy, ex_, ey_, ax, ay) || on_seg(cx, cy, ex_, ey_, bx, by))
                    r.status = STATUS_OVERLAP;
            end
            pending_crossings.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [31:0] x, logic [31:0] y);
            crossing_t e;
            if (pending_crossings.size() == 0) begin
                $error("result with nothing expected: status %0d", st);
                fail_count++;
                return;
            end
            e = pending_crossings.pop_front();
            if (st !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, st);
                fail_count++;
            end
            if (x !== e.cross_x) begin
                $error("cross_x: expected %h, got %h", e.cross_x, x);
                fail_count++;
            end
            if (y !== e.cross_y) begin
                $error("cross_y: expected %h, got %h", e.cross_y, y);
                fail_count++;
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    seg_pair_t          cur = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic signed [31:0] m_cross_x;
    logic signed [31:0] m_cross_y;

    crossing_board board = new();
    seg_pair_t     pair_queue[$];
    bit            stimulus_built = 1'b0;
    int            burst_left = 0;
    int            gap_left = 0;
    int            stall_mode = 0;
    int            mode_cycles = 0;

    segment_pair_intersection_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_first_start_x(cur.first_start_x), .s_first_start_y(cur.first_start_y),
        .s_first_end_x(cur.first_end_x), .s_first_end_y(cur.first_end_y),
        .s_second_start_x(cur.second_start_x), .s_second_start_y(cur.second_start_y),
        .s_second_end_x(cur.second_end_x), .s_second_end_y(cur.second_end_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_cross_x(m_cross_x), .m_cross_y(m_cross_y)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic seg_pair_t mk(int a, int b, int c, int d, int e, int f, int g,
                                     int h);
        seg_pair_t p;
        p = '{16'(a), 16'(b), 16'(c), 16'(d), 16'(e), 16'(f), 16'(g), 16'(h)};
        return p;
    endfunction

    function automatic int rnd_small(int lim);
        return $urandom_range(2 * lim) - lim;
    endfunction

    // Two segments laid on one line, so collinear cases come up often.
    function automatic seg_pair_t collinear_pair();
        int px, py, dx, dy, t0, t1, t2, t3;
        px = rnd_small(3000);
        py = rnd_small(3000);
        dx = rnd_small(9);
        dy = rnd_small(9);
        t0 = rnd_small(6); t1 = rnd_small(6); t2 = rnd_small(6); t3 = rnd_small(6);
        return mk(px + dx * t0, py + dy * t0, px + dx * t1, py + dy * t1,
                  px + dx * t2, py + dy * t2, px + dx * t3, py + dy * t3);
    endfunction

    function automatic seg_pair_t random_pair();
        int k;
        int lim;
        k = $urandom_range(9);
        if (k < 3)
            return seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
        if (k < 5)
            return collinear_pair();
        // Small boxes give many crossings, shared endpoints and parallels.
        lim = (k < 8) ? 6 : 300;
        return mk(rnd_small(lim), rnd_small(lim), rnd_small(lim), rnd_small(lim),
                  rnd_small(lim), rnd_small(lim), rnd_small(lim), rnd_small(lim));
    endfunction

    // Sender: bursts of items with idle gaps between them.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0 || pair_queue.size() == 0) begin
                if (gap_left > 0)
                    gap_left--;
                s_valid <= 1'b0;
            end else begin
                cur     <= pair_queue.pop_front();
                s_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(30);
                    gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
                end
            end
        end
    end

    // Receiver: switches between always ready, random stalls and long stalls.
    always @(posedge aclk) begin
        if (mode_cycles == 0) begin
            stall_mode  = $urandom_range(2);
            mode_cycles = $urandom_range(20, 200);
        end else begin
            mode_cycles--;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(1);
            default: m_ready <= ($urandom_range(5) == 0);
        endcase
    end

    // Monitor: note taken items and check results.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            board.note_pair(cur);
        if (aresetn && m_valid && m_ready)
            board.check_result(m_status, m_cross_x, m_cross_y);
    end

    initial begin
        // Extremes, crossings at corners and ends, parallels, overlaps, points.
        pair_queue.push_back(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        pair_queue.push_back(mk(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
        pair_queue.push_back(mk(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        pair_queue.push_back(mk(0, 0, 4, 4, 0, 4, 4, 0));
        pair_queue.push_back(mk(0, 0, 3, 1, 0, 1, 3, 0));
        pair_queue.push_back(mk(0, 0, -7, 3, -1, 5, -4, -2));
        pair_queue.push_back(mk(0, 0, 4, 0, 4, 0, 4, 5));
        pair_queue.push_back(mk(0, 0, 4, 0, 5, -1, 5, 1));
        pair_queue.push_back(mk(0, 0, 4, 0, 2, 1, 2, 3));
        pair_queue.push_back(mk(0, 0, 4, 0, 0, 1, 4, 1));
        pair_queue.push_back(mk(0, 0, 4, 0, 2, 0, 6, 0));
        pair_queue.push_back(mk(0, 0, 4, 0, 4, 0, 8, 0));
        pair_queue.push_back(mk(0, 0, 4, 0, 5, 0, 8, 0));
        pair_queue.push_back(mk(-2, -2, 6, 6, 1, 1, 2, 2));
        pair_queue.push_back(mk(3, 3, 3, 3, 0, 0, 5, 5));
        pair_queue.push_back(mk(0, 0, 5, 5, 7, -1, 7, -1));
        pair_queue.push_back(mk(1, 1, 1, 1, 1, 1, 1, 1));
        pair_queue.push_back(mk(32767, 32767, -32768, -32768, 32767, 32767, 0, 0));
        pair_queue.push_back(mk(-32768, -32768, -32767, 32767, 32767, -32768,
                                -32768, -32767));
        pair_queue.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1));
        for (int i = 0; i < 2000; i++)
            pair_queue.push_back(random_pair());
        stimulus_built = 1'b1;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        wait (stimulus_built);
        while (pair_queue.size() != 0 || s_valid || board.pending_crossings.size() != 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (board.fail_count == 0 && board.pending_crossings.size() == 0) begin
            $display("TB_OK");
        end else begin
            if (board.pending_crossings.size() != 0)
                $error("%0d results never arrived", board.pending_crossings.size());
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
